FILE: hw/rtl/irt_pkg.sv
package irt_pkg;

    localparam int ROW_FIELD_W   = 10;
    localparam int SEAT_FIELD_W  = 16;
    localparam int OWNER_FIELD_W = 16;
    localparam int STATUS_W      = 3;

    localparam logic ACT_RESERVE = 1'b0;
    localparam logic ACT_LOOKUP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOONE    = 3'd4;

    typedef struct packed {
        logic                     action;
        logic [ROW_FIELD_W-1:0]   row_index;
        logic [SEAT_FIELD_W-1:0]  first_seat;
        logic [SEAT_FIELD_W-1:0]  last_seat;
        logic [OWNER_FIELD_W-1:0] owner_tag;
        logic [SEAT_FIELD_W-1:0]  query_seat;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [OWNER_FIELD_W-1:0] found_owner;
    } t_resp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/irt_ram.sv
module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/irt_ctrl.sv
module irt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  irt_pkg::t_sts i_sts,
    output irt_pkg::t_cmd o_cmd
);

    irt_pkg::t_state r_state;
    irt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= irt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            irt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = irt_pkg::S_SCAN;
                end
            end
            irt_pkg::S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = irt_pkg::S_FINISH;
                end
            end
            irt_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = irt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = irt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall       = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.scan    = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            irt_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            irt_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            irt_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/irt_datapath.sv
module irt_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUM_ROWS    = 1024,
    parameter int SEAT_BITS   = 16,
    parameter int OWNER_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  irt_pkg::t_req  i_req,
    input  irt_pkg::t_cmd  i_cmd,
    output irt_pkg::t_sts  o_sts,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output irt_pkg::t_resp o_resp
);

    localparam int ROW_FW   = irt_pkg::ROW_FIELD_W;
    localparam int SEAT_FW  = irt_pkg::SEAT_FIELD_W;
    localparam int OWN_FW   = irt_pkg::OWNER_FIELD_W;
    localparam int ROW_LOG  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ROW_W    = (ROW_LOG < ROW_FW) ? ROW_LOG : ROW_FW;
    localparam int SEAT_W   = (SEAT_BITS < SEAT_FW) ? SEAT_BITS : SEAT_FW;
    localparam int OWNER_W  = (OWNER_BITS < OWN_FW) ? OWNER_BITS : OWN_FW;
    localparam int ENTRY_W  = ROW_W + 2 * SEAT_W + OWNER_W;
    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int OWN_LSB  = 0;
    localparam int LAST_LSB = OWNER_W;
    localparam int FRST_LSB = OWNER_W + SEAT_W;
    localparam int ROW_LSB  = OWNER_W + 2 * SEAT_W;

    irt_pkg::t_req  r_req;
    irt_pkg::t_resp r_resp;
    irt_pkg::t_resp n_resp;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   n_idx;
    logic               r_pend;
    logic               n_pend;
    logic               r_hit;
    logic               n_hit;
    logic [OWNER_W-1:0] r_owner;
    logic [OWNER_W-1:0] n_owner;
    logic               r_out_vld;
    logic               n_out_vld;

    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [ROW_W-1:0]   rd_row;
    logic [SEAT_W-1:0]  rd_first;
    logic [SEAT_W-1:0]  rd_last;
    logic [OWNER_W-1:0] rd_owner;
    logic [ROW_W-1:0]   req_row;
    logic [SEAT_W-1:0]  req_first;
    logic [SEAT_W-1:0]  req_last;
    logic [SEAT_W-1:0]  req_seat;
    logic [OWNER_W-1:0] req_owner;
    logic               is_reserve;
    logic               row_ok;
    logic               issue;
    logic               overlap;
    logic               covers;
    logic               match_now;
    logic               table_full;
    logic               do_write;

    irt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        rd_row     = rd_data[ROW_LSB +: ROW_W];
        rd_first   = rd_data[FRST_LSB +: SEAT_W];
        rd_last    = rd_data[LAST_LSB +: SEAT_W];
        rd_owner   = rd_data[OWN_LSB +: OWNER_W];
        req_row    = r_req.row_index[ROW_W-1:0];
        req_first  = r_req.first_seat[SEAT_W-1:0];
        req_last   = r_req.last_seat[SEAT_W-1:0];
        req_seat   = r_req.query_seat[SEAT_W-1:0];
        req_owner  = r_req.owner_tag[OWNER_W-1:0];
        wr_data    = {req_row, req_first, req_last, req_owner};
        is_reserve = (r_req.action == irt_pkg::ACT_RESERVE);
        row_ok     = (32'(r_req.row_index) < 32'(NUM_ROWS));
        table_full = (r_count == CNT_W'(TABLE_DEPTH));

        overlap    = !((req_first > rd_last) || (rd_first > req_last));
        covers     = (rd_first <= req_seat) && (rd_last >= req_seat);
        match_now  = r_pend && row_ok && (rd_row == req_row) &&
                     (is_reserve ? overlap : covers);
        issue      = i_cmd.scan && (r_idx < r_count);

        o_sts.scan_end = !row_ok || match_now || (r_idx == r_count);
        o_sts.out_free = !r_out_vld || !i_out_stall;

        do_write = i_cmd.finish && is_reserve && row_ok && !r_hit && !table_full;
    end

    always_comb begin
        n_idx     = r_idx;
        n_pend    = i_cmd.scan ? issue : 1'b0;
        n_hit     = r_hit;
        n_owner   = r_owner;
        n_count   = r_count;
        n_out_vld = r_out_vld;
        n_resp    = r_resp;

        if (i_cmd.capture) begin
            n_idx = '0;
            n_hit = 1'b0;
        end else if (issue) begin
            n_idx = r_idx + CNT_W'(1);
        end

        if (i_cmd.scan && match_now) begin
            n_hit   = 1'b1;
            n_owner = rd_owner;
        end

        if (do_write) begin
            n_count = r_count + CNT_W'(1);
        end

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        if (i_cmd.finish) begin
            n_out_vld          = 1'b1;
            n_resp.found_owner = '0;
            if (is_reserve) begin
                if (r_hit || !row_ok) begin
                    n_resp.status = irt_pkg::ST_OVERLAP;
                end else if (table_full) begin
                    n_resp.status = irt_pkg::ST_FULL;
                end else begin
                    n_resp.status = irt_pkg::ST_RESERVED;
                end
            end else if (r_hit) begin
                n_resp.status      = irt_pkg::ST_FOUND;
                n_resp.found_owner = OWN_FW'(r_owner);
            end else begin
                n_resp.status = irt_pkg::ST_NOONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_owner <= n_owner;
        r_resp  <= n_resp;
    end

    assign o_out_valid = r_out_vld;
    assign o_resp      = r_resp;

endmodule

FILE: hw/rtl/interval_reservation_table_core.sv
// Seat range reservation table. Each request either reserves an inclusive
// seat range in a row for an owner tag, or looks up who holds one seat; every
// request yields exactly one response. Stored ranges live in one RAM of
// TABLE_DEPTH entries with a single registered read port, scanned one entry
// per cycle in the order they were stored; a reserve stops at the first
// clash in the same row, a lookup at the first covering range. A request is
// accepted, scans the stored entries up to the first hit, then posts its
// response, appending a granted range, once the output register is free.
// The response sits in an output register, so a new request is accepted
// while the previous response is still stalled. No clearing pass is needed
// after reset; only entries already written are ever read.
module interval_reservation_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int NUM_ROWS    = 1024,
    parameter int SEAT_BITS   = 16,
    parameter int OWNER_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  irt_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output irt_pkg::t_resp o_resp
);

    irt_pkg::t_cmd cmd;
    irt_pkg::t_sts sts;

    irt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    irt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_ROWS    (NUM_ROWS),
        .SEAT_BITS   (SEAT_BITS),
        .OWNER_BITS  (OWNER_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_resp      (o_resp)
    );

endmodule

FILE: hw/rtl/irt_checker.sv
module irt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input irt_pkg::t_req  i_req,
    input logic           o_valid,
    input logic           i_stall,
    input irt_pkg::t_resp o_resp
);

    // a stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_resp)))
        else $error("stalled response changed");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while busy");

    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_resp.status != irt_pkg::ST_FOUND)) |->
            (o_resp.found_owner == '0))
        else $error("owner set without found status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_resp.status <= irt_pkg::ST_NOONE))
        else $error("bad status code");

endmodule

bind interval_reservation_table_core irt_checker u_irt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_resp  (o_resp)
);
